@@ rtl/atilt_pkg.sv @@
// Package: shared constants, types and the CORDIC angle table for the tilt filter.
`timescale 1ns / 1ps
`default_nettype none
package atilt_pkg;
	localparam int CordicSteps = 20;
	localparam int StepW = 5;
	localparam int XW = 36;
	localparam int YW = 36;
	localparam int ZW = 24;
	localparam int SqW = 48;
	localparam int RootW = 24;
	localparam int SqrtIter = 24;
	localparam int SqrtCntW = 5;
	localparam logic signed [17:0] AngleLimit = 18'sd46080;

	localparam logic [3:0] DirStop = 4'd0;
	localparam logic [3:0] DirFwd = 4'd1;
	localparam logic [3:0] DirBack = 4'd2;
	localparam logic [3:0] DirRight = 4'd3;
	localparam logic [3:0] DirLeft = 4'd4;
	localparam logic [3:0] DirFwdRight = 4'd5;
	localparam logic [3:0] DirFwdLeft = 4'd6;
	localparam logic [3:0] DirBackRight = 4'd7;
	localparam logic [3:0] DirBackLeft = 4'd8;
	localparam logic [3:0] DirNone = 4'd9;

	localparam logic [1:0] ClsCentre = 2'd0;
	localparam logic [1:0] ClsPlus = 2'd1;
	localparam logic [1:0] ClsMinus = 2'd2;
	localparam logic [1:0] ClsEdge = 2'd3;

	localparam logic [1:0] RegPitchTrim = 2'd0;
	localparam logic [1:0] RegRollTrim = 2'd1;
	localparam logic [1:0] RegNewWeight = 2'd2;
	localparam logic [1:0] RegDeadZone = 2'd3;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [YW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_vec_t;

	function automatic logic signed [ZW-1:0] atan_entry(input logic [StepW-1:0] i);
		logic signed [ZW-1:0] v;
		case (i)
			5'd0: v = 24'sd2949120;
			5'd1: v = 24'sd1740967;
			5'd2: v = 24'sd919879;
			5'd3: v = 24'sd466945;
			5'd4: v = 24'sd234379;
			5'd5: v = 24'sd117304;
			5'd6: v = 24'sd58666;
			5'd7: v = 24'sd29335;
			5'd8: v = 24'sd14668;
			5'd9: v = 24'sd7334;
			5'd10: v = 24'sd3667;
			5'd11: v = 24'sd1833;
			5'd12: v = 24'sd917;
			5'd13: v = 24'sd458;
			5'd14: v = 24'sd229;
			5'd15: v = 24'sd115;
			5'd16: v = 24'sd57;
			5'd17: v = 24'sd29;
			5'd18: v = 24'sd14;
			5'd19: v = 24'sd7;
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

@@ rtl/atilt_if.sv @@
// Interfaces: valid/ready channels for samples and results.
`timescale 1ns / 1ps
`default_nettype none
interface atilt_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] accel_x_raw;
	logic signed [15:0] accel_y_raw;
	logic signed [15:0] accel_z_raw;
	modport source (output valid, accel_x_raw, accel_y_raw, accel_z_raw, input ready);
	modport sink (input valid, accel_x_raw, accel_y_raw, accel_z_raw, output ready);
endinterface

interface atilt_out_if;
	logic valid;
	logic ready;
	logic signed [16:0] pitch_out;
	logic signed [16:0] roll_out;
	logic [3:0] direction;
	modport source (output valid, pitch_out, roll_out, direction, input ready);
	modport sink (input valid, pitch_out, roll_out, direction, output ready);
endinterface
`default_nettype wire

@@ rtl/atilt_cordic_cell.sv @@
// CORDIC cell: one vectoring rotation per cycle, hands its vector to the next cell.
`timescale 1ns / 1ps
`default_nettype none
module atilt_cordic_cell
	import atilt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [StepW-1:0] step,
	input wire logic in_vld,
	input wire cordic_vec_t vec_in,
	output logic out_vld,
	output cordic_vec_t vec_out
);
	cordic_vec_t nxt;

	always_comb begin
		nxt = vec_in;
		if (vec_in.y >= 0) begin
			nxt.x = vec_in.x + (vec_in.y >>> step);
			nxt.y = vec_in.y - (vec_in.x >>> step);
			nxt.z = vec_in.z + atan_entry(step);
		end else begin
			nxt.x = vec_in.x - (vec_in.y >>> step);
			nxt.y = vec_in.y + (vec_in.x >>> step);
			nxt.z = vec_in.z - atan_entry(step);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			vec_out <= nxt;
		end
	end
endmodule
`default_nettype wire

@@ rtl/atilt_sqrt.sv @@
// Square root: restoring, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module atilt_sqrt
	import atilt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [SqW-1:0] radicand,
	output logic done,
	output logic [RootW-1:0] root
);
	logic [SqW-1:0] rem_q;
	logic [SqW-1:0] res_q;
	logic [SqW-1:0] bit_q;
	logic [SqrtCntW-1:0] cnt_q;
	logic busy_q;
	logic [SqW-1:0] trial;

	assign trial = res_q + bit_q;
	assign root = res_q[RootW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SqrtCntW'(SqrtIter - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= {2'b01, {(SqW-2){1'b0}}};
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule
`default_nettype wire

@@ rtl/accel_tilt_angle_filter_unit.sv @@
// Top level: tilt angles through a CORDIC cell chain, low-pass, trim and direction.
`timescale 1ns / 1ps
`default_nettype none
// One sample is taken at a time. Steps after a sample is accepted:
// - The squares are registered.
// - A registered start launches the square root.
// - The square root loads its radicand and then finds the 24 result bits. It is shared,
//   so pitch and roll take two passes.
// - The pitch vector runs down the 20 CORDIC cells while the roll root is computed.
// - The roll vector then runs through the chain.
// - Both angles are registered, then the filter and saturation are registered.
// The next sample can be taken in the cycle after the result beat leaves, so every
// stall on the result channel delays it.
// A weight above 256 acts as 256.
// An all-zero sample is dropped at once and leaves the state as it was.
// Trim, weight and dead zone are written over the APB port. The user must write them
// only while the block is idle; the block itself does not enforce this.
module accel_tilt_angle_filter_unit
	import atilt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	atilt_in_if.sink in_ch,
	atilt_out_if.source out_ch,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StSqP = 3'd1;
	localparam logic [2:0] StSqR = 3'd2;
	localparam logic [2:0] StChain = 3'd3;
	localparam logic [2:0] StFilt = 3'd4;
	localparam logic [2:0] StOut = 3'd5;

	logic signed [15:0] pitch_trim_q, roll_trim_q;
	logic [8:0] new_weight_q;
	logic [15:0] dead_zone_q;
	logic [2:0] state_q;
	logic signed [15:0] x_q, y_q, z_q;
	logic [SqW-1:0] sqp_q, sqr_q;
	logic [RootW-1:0] rootp_q;
	logic signed [16:0] pf_q, rf_q;
	logic sq_done;
	logic [RootW-1:0] sq_root;
	logic [SqW-1:0] sq_rad;
	logic sq_go_q;
	logic root_is_roll_q;
	logic pit_go_q;
	logic chain_in_vld;
	cordic_vec_t chain_in;
	logic chain_vld [CordicSteps+1];
	cordic_vec_t chain_vec [CordicSteps+1];
	logic signed [ZW-1:0] zp_q;
	logic got_p_q;
	logic signed [ZW-1:0] ang_z_p, ang_z_r;
	logic signed [17:0] ang_p_s1, ang_r_s1;
	logic signed [28:0] mix_p, mix_r;
	logic signed [9:0] w_eff, w_old;
	logic signed [18:0] f_p, f_r;
	logic signed [17:0] sat_p, sat_r;
	logic [1:0] cls_p, cls_r;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign in_ch.ready = (state_q == StIdle);

	always_comb begin
		case (paddr[3:2])
			RegPitchTrim: prdata = {{16{pitch_trim_q[15]}}, pitch_trim_q};
			RegRollTrim: prdata = {{16{roll_trim_q[15]}}, roll_trim_q};
			RegNewWeight: prdata = {23'd0, new_weight_q};
			RegDeadZone: prdata = {16'd0, dead_zone_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_trim_q <= '0;
			roll_trim_q <= '0;
			new_weight_q <= 9'd77;
			dead_zone_q <= 16'd2560;
		end else if (wr_en) begin
			case (paddr[3:2])
				RegPitchTrim: pitch_trim_q <= pwdata[15:0];
				RegRollTrim: roll_trim_q <= pwdata[15:0];
				RegNewWeight: new_weight_q <= pwdata[8:0];
				RegDeadZone: dead_zone_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// square root shared by pitch then roll
	assign sq_rad = root_is_roll_q ? sqr_q : sqp_q;

	atilt_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_go_q), .radicand(sq_rad),
		.done(sq_done), .root(sq_root)
	);

	// pitch vector enters while the roll root is computed, roll follows when its root is done
	assign chain_in_vld = pit_go_q || (sq_done && root_is_roll_q);
	always_comb begin
		chain_in.z = '0;
		if (pit_go_q) begin
			chain_in.x = {{(XW-RootW){1'b0}}, rootp_q};
			chain_in.y = {{(YW-24){x_q[15]}}, x_q, 8'd0};
		end else begin
			chain_in.x = {{(XW-RootW){1'b0}}, sq_root};
			chain_in.y = {{(YW-24){y_q[15]}}, y_q, 8'd0};
		end
	end
	assign chain_vld[0] = chain_in_vld;
	assign chain_vec[0] = chain_in;

	genvar gi;
	generate
		for (gi = 0; gi < CordicSteps; gi++) begin : g_cell
			atilt_cordic_cell u_cell (
				.clk(clk), .arst_n(arst_n), .step(StepW'(gi)),
				.in_vld(chain_vld[gi]), .vec_in(chain_vec[gi]),
				.out_vld(chain_vld[gi+1]), .vec_out(chain_vec[gi+1])
			);
		end
	endgenerate

	assign ang_z_p = zp_q + ZW'(128);
	assign ang_z_r = chain_vec[CordicSteps].z + ZW'(128);
	assign w_eff = (new_weight_q > 9'd256) ? 10'sd256 : $signed({1'b0, new_weight_q});
	assign w_old = 10'sd256 - w_eff;
	assign mix_p = w_eff * ang_p_s1 + w_old * pf_q + 29'sd128;
	assign mix_r = w_eff * ang_r_s1 + w_old * rf_q + 29'sd128;
	assign f_p = 19'(mix_p >>> 8) - 19'(pitch_trim_q);
	assign f_r = 19'(mix_r >>> 8) - 19'(roll_trim_q);

	function automatic logic signed [17:0] sat(input logic signed [18:0] v);
		logic signed [17:0] r;
		if (v > 19'sd46080) r = AngleLimit;
		else if (v < -19'sd46080) r = -AngleLimit;
		else r = v[17:0];
		return r;
	endfunction

	function automatic logic [1:0] classify(input logic signed [16:0] a,
		input logic [15:0] dz);
		logic signed [17:0] d, aa;
		logic [1:0] c;
		d = $signed({2'b00, dz});
		aa = 18'(a);
		if (aa > d) c = ClsPlus;
		else if (aa < -d) c = ClsMinus;
		else if (aa < d && aa > -d) c = ClsCentre;
		else c = ClsEdge;
		return c;
	endfunction

	assign sat_p = sat(f_p);
	assign sat_r = sat(f_r);
	assign cls_p = classify(out_ch.pitch_out, dead_zone_q);
	assign cls_r = classify(out_ch.roll_out, dead_zone_q);

	always_comb begin
		out_ch.direction = DirNone;
		if (cls_p != ClsEdge && cls_r != ClsEdge) begin
			case ({cls_p, cls_r})
				{ClsCentre, ClsCentre}: out_ch.direction = DirStop;
				{ClsCentre, ClsPlus}: out_ch.direction = DirRight;
				{ClsCentre, ClsMinus}: out_ch.direction = DirLeft;
				{ClsPlus, ClsCentre}: out_ch.direction = DirFwd;
				{ClsPlus, ClsPlus}: out_ch.direction = DirFwdRight;
				{ClsPlus, ClsMinus}: out_ch.direction = DirFwdLeft;
				{ClsMinus, ClsCentre}: out_ch.direction = DirBack;
				{ClsMinus, ClsPlus}: out_ch.direction = DirBackRight;
				{ClsMinus, ClsMinus}: out_ch.direction = DirBackLeft;
				default: out_ch.direction = DirNone;
			endcase
		end
	end

	assign out_ch.pitch_out = pf_q;
	assign out_ch.roll_out = rf_q;
	assign out_ch.valid = (state_q == StOut);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			pf_q <= '0;
			rf_q <= '0;
			root_is_roll_q <= 1'b0;
			sq_go_q <= 1'b0;
			pit_go_q <= 1'b0;
			got_p_q <= 1'b0;
		end else begin
			sq_go_q <= 1'b0;
			pit_go_q <= 1'b0;
			case (state_q)
				StIdle: begin
					if (in_ch.valid && (in_ch.accel_x_raw != 0 || in_ch.accel_y_raw != 0
						|| in_ch.accel_z_raw != 0)) begin
						state_q <= StSqP;
					end
				end
				StSqP: begin
					root_is_roll_q <= 1'b0;
					sq_go_q <= 1'b1;
					got_p_q <= 1'b0;
					state_q <= StSqR;
				end
				StSqR: begin
					if (sq_done && !root_is_roll_q) begin
						root_is_roll_q <= 1'b1;
						sq_go_q <= 1'b1;
						pit_go_q <= 1'b1;
						state_q <= StChain;
					end
				end
				StChain: begin
					if (chain_vld[CordicSteps]) begin
						if (!got_p_q) begin
							got_p_q <= 1'b1;
						end else begin
							state_q <= StFilt;
						end
					end
				end
				StFilt: begin
					pf_q <= sat_p[16:0];
					rf_q <= sat_r[16:0];
					state_q <= StOut;
				end
				StOut: begin
					if (out_ch.ready) begin
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == StIdle && in_ch.valid) begin
			x_q <= in_ch.accel_x_raw;
			y_q <= in_ch.accel_y_raw;
			z_q <= in_ch.accel_z_raw;
		end
		if (state_q == StSqP) begin
			sqp_q <= SqW'((32'(y_q * y_q) + 32'(z_q * z_q))) << 16;
			sqr_q <= SqW'((32'(x_q * x_q) + 32'(z_q * z_q))) << 16;
		end
		if (sq_done && !root_is_roll_q) begin
			rootp_q <= sq_root;
		end
		if (state_q == StChain && chain_vld[CordicSteps]) begin
			if (!got_p_q) begin
				zp_q <= chain_vec[CordicSteps].z;
			end else begin
				ang_p_s1 <= 18'(ang_z_p >>> 8);
				ang_r_s1 <= 18'(ang_z_r >>> 8);
			end
		end
	end
endmodule
`default_nettype wire
